@@ rtl/core/slpg_pkg.sv @@
// Shared constants, types and sine table builder for the status LED pattern generator.
package slpg_pkg;

  // Quarter-wave sine table size and PWM level resolution
  localparam int QUARTER_SINE_ENTRIES = 1000;
  localparam int LEVEL_BITS           = 16;

  localparam int SINE_ADDR_BITS = $clog2(QUARTER_SINE_ENTRIES + 1);
  localparam int SINE_BITS      = 15;

  // Timebase
  localparam int COUNT_BITS   = 13;
  localparam int CYCLE_MS     = 8000;
  localparam int QUARTER_MS   = 1000;
  localparam int QMS_BITS     = 10;
  localparam int FAST_MS      = 400;
  localparam int FAST_BITS    = 9;
  localparam int SLOW_MS      = 1600;
  localparam int SLOW_BITS    = 11;

  // Brightness, Q0.16
  localparam logic [15:0] DEFAULT_TOP = 16'd255;
  localparam logic [15:0] FLOOR_Q16   = 16'd6554;
  localparam logic [15:0] SWING_Q16   = 16'd29491;
  localparam logic [16:0] SINE_MID    = 17'd32768;

  // Serial multiplier, two multiplier bits per step
  localparam int MUL_A_BITS  = 16;
  localparam int MUL_B_BITS  = 18;
  localparam int MUL_DIGITS  = MUL_B_BITS / 2;
  localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS + 1);

  // Modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_BREATHE = 3'd2;
  localparam logic [2:0] MODE_FAST    = 3'd3;
  localparam logic [2:0] MODE_SLOW    = 3'd4;

  // Register indexes
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_PWM_TOP = 1'b1;

  // Q30 coefficients of the odd series of sin(pi/2 * x)
  localparam logic [63:0] A1 = 64'd1686629713;
  localparam logic [63:0] A3 = 64'd693598669;
  localparam logic [63:0] A5 = 64'd85569306;
  localparam logic [63:0] A7 = 64'd5026995;
  localparam logic [63:0] A9 = 64'd172272;

  typedef struct packed {
    logic [COUNT_BITS-1:0]     count;
    logic [1:0]                quadrant;
    logic [SINE_ADDR_BITS-1:0] u;
    logic [FAST_BITS-1:0]      fast;
    logic [SLOW_BITS-1:0]      slow;
  } phase_t;

  typedef logic [SINE_BITS-1:0] sine_rom_t [0:QUARTER_SINE_ENTRIES];

  // Elaboration-time only: one Q0.15 sample of the quarter wave
  function automatic logic [SINE_BITS-1:0] sine_sample(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) << 30) / 64'(QUARTER_SINE_ENTRIES);
    x2 = (x * x) >> 30;
    h  = A9;
    h  = A7 - ((x2 * h) >> 30);
    h  = A5 - ((x2 * h) >> 30);
    h  = A3 - ((x2 * h) >> 30);
    h  = A1 - ((x2 * h) >> 30);
    s  = (x * h) >> 30;
    v  = (s + 64'd16384) >> 15;
    return (v > 64'd32767) ? 15'h7fff : v[SINE_BITS-1:0];
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int i = 0; i <= QUARTER_SINE_ENTRIES; i++) begin
      rom[i] = sine_sample(i);
    end
    return rom;
  endfunction

endpackage

@@ rtl/core/slpg_timebase.sv @@
// Millisecond counter with incrementally tracked pattern phases.
module slpg_timebase (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  output slpg_pkg::phase_t phase
);

  logic [slpg_pkg::COUNT_BITS-1:0]     count;
  logic [1:0]                          quadrant;
  logic [slpg_pkg::QMS_BITS-1:0]       qms;     // ms within quarter
  logic [slpg_pkg::SINE_ADDR_BITS-1:0] u;       // floor(qms * N / 1000)
  logic [slpg_pkg::QMS_BITS-1:0]       acc;     // qms * N mod 1000
  logic [slpg_pkg::FAST_BITS-1:0]      fast;
  logic [slpg_pkg::SLOW_BITS-1:0]      slow;
  logic [slpg_pkg::QMS_BITS:0]         acc_sum;

  assign acc_sum = {1'b0, acc} + (slpg_pkg::QMS_BITS + 1)'(slpg_pkg::QUARTER_SINE_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      quadrant <= '0;
      qms      <= '0;
      u        <= '0;
      acc      <= '0;
      fast     <= '0;
      slow     <= '0;
    end else if (step) begin
      count <= (count == slpg_pkg::COUNT_BITS'(slpg_pkg::CYCLE_MS - 1))
               ? '0 : count + 1'b1;
      fast  <= (fast == slpg_pkg::FAST_BITS'(slpg_pkg::FAST_MS - 1))
               ? '0 : fast + 1'b1;
      slow  <= (slow == slpg_pkg::SLOW_BITS'(slpg_pkg::SLOW_MS - 1))
               ? '0 : slow + 1'b1;
      if (qms == slpg_pkg::QMS_BITS'(slpg_pkg::QUARTER_MS - 1)) begin
        qms      <= '0;
        quadrant <= quadrant + 1'b1;
        u        <= '0;
        acc      <= '0;
      end else begin
        qms <= qms + 1'b1;
        if (acc_sum >= (slpg_pkg::QMS_BITS + 1)'(slpg_pkg::QUARTER_MS)) begin
          u   <= u + 1'b1;
          acc <= slpg_pkg::QMS_BITS'(acc_sum - (slpg_pkg::QMS_BITS + 1)'(slpg_pkg::QUARTER_MS));
        end else begin
          acc <= acc_sum[slpg_pkg::QMS_BITS-1:0];
        end
      end
    end
  end

  assign phase.count    = count;
  assign phase.quadrant = quadrant;
  assign phase.u        = u;
  assign phase.fast     = fast;
  assign phase.slow     = slow;

endmodule

@@ rtl/core/slpg_sine_rom.sv @@
// Quarter-wave Q0.15 sine ROM with registered read.
module slpg_sine_rom (
  input  logic                                clk,
  input  logic [slpg_pkg::SINE_ADDR_BITS-1:0] addr,
  output logic [slpg_pkg::SINE_BITS-1:0]      data
);

  localparam slpg_pkg::sine_rom_t ROM = slpg_pkg::sine_rom_build();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

@@ rtl/core/slpg_serial_mult.sv @@
// Radix-4 serial shift-add multiplier, two multiplier bits per cycle.
module slpg_serial_mult (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [slpg_pkg::MUL_A_BITS-1:0]    a,
  input  logic [slpg_pkg::MUL_B_BITS-1:0]    b,
  output logic                               busy,
  output logic [slpg_pkg::MUL_P_BITS-1:0]    product
);

  localparam int HI_BITS = slpg_pkg::MUL_A_BITS + 2;
  localparam int P_BITS  = HI_BITS + slpg_pkg::MUL_B_BITS;

  logic [slpg_pkg::MUL_A_BITS-1:0]   a_reg;
  logic [P_BITS-1:0]                 acc;
  logic [slpg_pkg::MUL_CNT_BITS-1:0] cnt;
  logic [HI_BITS-1:0]                partial;
  logic [HI_BITS-1:0]                hi_sum;
  logic [P_BITS-1:0]                 acc_next;

  always_comb begin
    case (acc[1:0])
      2'd1:    partial = HI_BITS'(a_reg);
      2'd2:    partial = HI_BITS'(a_reg) << 1;
      2'd3:    partial = HI_BITS'(a_reg) + (HI_BITS'(a_reg) << 1);
      default: partial = '0;
    endcase
    hi_sum   = acc[P_BITS-1 -: HI_BITS] + partial;
    acc_next = {hi_sum, acc[slpg_pkg::MUL_B_BITS-1:0]} >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= slpg_pkg::MUL_CNT_BITS'(slpg_pkg::MUL_DIGITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == slpg_pkg::MUL_CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      acc   <= {{HI_BITS{1'b0}}, b};
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign product = acc[slpg_pkg::MUL_P_BITS-1:0];

endmodule

@@ rtl/core/status_led_pattern_generator_unit.sv @@
// Top level of the status LED pattern generator: sequencer, config registers and output stage.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------------
//  s_*      | in  | s_tvalid/tready  | s_tdata[0] advance, [7:1] zero
//  m_*      | out | m_tvalid/tready  | m_tdata[15:0] pwm_level, [28:16] time_in_cycle
//  cfg_*    | in  | cfg_we           | cfg_addr 0 mode, 1 pwm_top; cfg_data
//
// Each item runs from its transfer until the block can take the next one through
// ROM read, two 9-step radix-4 serial multiplies (swing times sine offset, then
// brightness times top) with a launch state and a wait state each, and output load.
// All modes run the same sequence. Reset (rst, synchronous) clears the counter,
// sets mode to off and pwm_top to 255. A finished result waits in the output
// register; the sequencer stalls at its final step only while that register is full.
module status_led_pattern_generator_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] pwm_level, [28:16] time_in_cycle, [31:29] zero
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROM  = 3'd1;
  localparam logic [2:0] S_M1GO = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2GO = 3'd4;
  localparam logic [2:0] S_M2   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [2:0]  mode;
  logic [15:0] pwm_top;
  logic [15:0] top_eff;

  logic                                s_xfer;
  logic                                out_load;
  slpg_pkg::phase_t                    phase;
  logic [slpg_pkg::SINE_ADDR_BITS-1:0] sine_addr;
  logic [slpg_pkg::SINE_BITS-1:0]      sine;
  logic [16:0]                         sine_off;

  logic                                mul_start;
  logic                                mul_busy;
  logic [slpg_pkg::MUL_A_BITS-1:0]     mul_a;
  logic [slpg_pkg::MUL_B_BITS-1:0]     mul_b;
  logic [slpg_pkg::MUL_P_BITS-1:0]     mul_p;

  logic [16:0]                         bright_sum;
  logic [15:0]                         bright;
  logic [slpg_pkg::LEVEL_BITS-1:0]     bright_q;
  logic [15:0]                         level;

  assign s_xfer   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= slpg_pkg::MODE_OFF;
      pwm_top <= slpg_pkg::DEFAULT_TOP;
    end else if (cfg_we) begin
      case (cfg_addr)
        slpg_pkg::REG_MODE:    mode    <= cfg_data[2:0];
        slpg_pkg::REG_PWM_TOP: pwm_top <= cfg_data;
        default:               mode    <= mode;
      endcase
    end
  end

  assign top_eff = (pwm_top == 16'd0) ? slpg_pkg::DEFAULT_TOP : pwm_top;

  slpg_timebase u_timebase (
    .clk   (clk),
    .rst   (rst),
    .step  (s_xfer && s_tdata[0]),
    .phase (phase)
  );

  // odd quadrants run the table backward
  assign sine_addr = phase.quadrant[0]
                   ? slpg_pkg::SINE_ADDR_BITS'(slpg_pkg::QUARTER_SINE_ENTRIES) - phase.u
                   : phase.u;

  slpg_sine_rom u_sine_rom (
    .clk  (clk),
    .addr (sine_addr),
    .data (sine)
  );

  // second half of the period is the negative lobe
  assign sine_off = phase.quadrant[1] ? slpg_pkg::SINE_MID - 17'(sine)
                                      : slpg_pkg::SINE_MID + 17'(sine);

  // brightness from first product, held in the multiplier until relaunch
  assign bright_sum = 17'(slpg_pkg::FLOOR_Q16) + 17'(mul_p[15 +: 16]);
  assign bright     = bright_sum[15:0];
  assign bright_q   = bright[15 -: slpg_pkg::LEVEL_BITS];

  assign mul_start = (state == S_M1GO) || (state == S_M2GO);
  assign mul_a     = (state == S_M1GO) ? slpg_pkg::SWING_Q16 : top_eff;
  assign mul_b     = (state == S_M1GO) ? slpg_pkg::MUL_B_BITS'(sine_off)
                                       : slpg_pkg::MUL_B_BITS'(bright_q);

  slpg_serial_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_p)
  );

  always_comb begin
    case (mode)
      slpg_pkg::MODE_ON:      level = top_eff;
      slpg_pkg::MODE_BREATHE: level = mul_p[slpg_pkg::LEVEL_BITS +: 16];
      slpg_pkg::MODE_FAST:
        level = (phase.fast < slpg_pkg::FAST_BITS'(slpg_pkg::FAST_MS / 2)) ? top_eff : 16'd0;
      slpg_pkg::MODE_SLOW:
        level = (phase.slow < slpg_pkg::SLOW_BITS'(slpg_pkg::SLOW_MS / 2)) ? top_eff : 16'd0;
      default:                level = 16'd0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_xfer) state_next = S_ROM;
      S_ROM:   state_next = S_M1GO;
      S_M1GO:  state_next = S_M1;
      S_M1:    if (!mul_busy) state_next = S_M2GO;
      S_M2GO:  state_next = S_M2;
      S_M2:    if (!mul_busy) state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, phase.count, level};
    end
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("item accepted while sequencer busy");

  a_mult_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier launched while busy");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[28:16] < 13'(slpg_pkg::CYCLE_MS)))
    else $error("time_in_cycle out of range");

  a_phase_align: assert property (@(posedge clk) disable iff (rst)
    (phase.count == '0) |-> (phase.fast == '0 && phase.slow == '0 &&
                             phase.quadrant == '0 && phase.u == '0))
    else $error("pattern phases out of step with counter");

endmodule

@@ test/tb_status_led_pattern_generator_unit.sv @@
// Self-checking testbench for the status LED pattern generator: directed, sweep and random runs.
`timescale 1ns / 100ps

module tb_status_led_pattern_generator_unit;

  // Mode codes that decode to nothing (behave like off)
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int BREATH_MS      = 4 * slpg_pkg::QUARTER_MS;
  localparam int SWEEP_SEGMENTS = 4;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int RANDOM_ITEMS   = 280;    // per idling profile, three profiles
  localparam int DRAIN_CYCLES   = 40;
  localparam int RUN_LIMIT_NS   = 30_000_000;
  localparam int PRINT_CAP      = 100;

  typedef struct {
    logic [15:0]                     level;
    logic [slpg_pkg::COUNT_BITS-1:0] ms;
  } led_sample_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [0] advance, [7:1] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] pwm_level, [28:16] time_in_cycle, [31:29] zero
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_data;

  // Shadow of the block's registers and millisecond counter
  logic [2:0]                      model_mode;
  logic [15:0]                     model_top;
  logic [slpg_pkg::COUNT_BITS-1:0] model_ms;

  // Expected samples, oldest first
  led_sample_t pending_samples[$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;

  status_led_pattern_generator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("** status_led_pattern_generator_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Q0.15 quarter-wave sample, odd Taylor series of sin(pi/2 * x) in Q30
  function automatic logic [slpg_pkg::SINE_BITS-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] xsq;
    logic [63:0] acc;
    logic [63:0] y;
    x   = (64'(k) << 30) / 64'(slpg_pkg::QUARTER_SINE_ENTRIES);
    xsq = (x * x) >> 30;
    acc = slpg_pkg::A7 - ((xsq * slpg_pkg::A9) >> 30);
    acc = slpg_pkg::A5 - ((xsq * acc) >> 30);
    acc = slpg_pkg::A3 - ((xsq * acc) >> 30);
    acc = slpg_pkg::A1 - ((xsq * acc) >> 30);
    y   = (((x * acc) >> 30) + 64'd16384) >> 15;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return y[slpg_pkg::SINE_BITS-1:0];
  endfunction

  // Breathing level: (0.1 + 0.45 * (1 + sin)) * top, truncated fixed point
  function automatic logic [15:0] breath_level(input int unsigned t, input int unsigned top);
    int unsigned pos;
    int unsigned quad;
    int unsigned idx;
    int unsigned sine;
    int unsigned swing;
    int unsigned bright;
    logic [63:0] scaled;
    pos  = t % BREATH_MS;
    quad = pos / slpg_pkg::QUARTER_MS;
    idx  = (pos % slpg_pkg::QUARTER_MS) * slpg_pkg::QUARTER_SINE_ENTRIES / slpg_pkg::QUARTER_MS;
    // odd quadrants run the table backwards, upper half of the period is negative
    if (quad[0]) begin
      idx = 32'(slpg_pkg::QUARTER_SINE_ENTRIES) - idx;
    end
    sine   = 32'(quarter_sine(idx));
    swing  = (quad >= 2) ? 32'(slpg_pkg::SINE_MID) - sine : 32'(slpg_pkg::SINE_MID) + sine;
    bright = 32'(slpg_pkg::FLOOR_Q16) + 32'((64'(slpg_pkg::SWING_Q16) * 64'(swing)) >> 15);
    bright = bright >> (16 - slpg_pkg::LEVEL_BITS);
    scaled = (64'(bright) * 64'(top)) >> slpg_pkg::LEVEL_BITS;
    return scaled[15:0];
  endfunction

  // Advance the shadow counter by one transfer and return the sample it yields
  function automatic led_sample_t step_pattern(input logic advance);
    int unsigned top;
    int unsigned t;
    led_sample_t smp;
    top      = (model_top == 16'd0) ? 32'(slpg_pkg::DEFAULT_TOP) : 32'(model_top);
    model_ms = slpg_pkg::COUNT_BITS'((int'(model_ms) + int'(advance)) % slpg_pkg::CYCLE_MS);
    t        = 32'(model_ms);
    case (model_mode)
      slpg_pkg::MODE_ON:      smp.level = 16'(top);
      slpg_pkg::MODE_BREATHE: smp.level = breath_level(t, top);
      slpg_pkg::MODE_FAST:
        smp.level = ((t % slpg_pkg::FAST_MS) < slpg_pkg::FAST_MS / 2) ? 16'(top) : 16'd0;
      slpg_pkg::MODE_SLOW:
        smp.level = ((t % slpg_pkg::SLOW_MS) < slpg_pkg::SLOW_MS / 2) ? 16'(top) : 16'd0;
      default:                smp.level = 16'd0;
    endcase
    smp.ms = model_ms;
    return smp;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_CAP) begin
      $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Output side: sample the handshake as the block saw it, then pick the next
  // tready value; stalls land on any cycle of the item computation.
  initial begin
    led_sample_t want;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("output transfer with no sample pending", m_tdata, 0);
        end else begin
          want = pending_samples.pop_front();
          if (m_tdata[15:0] !== want.level) begin
            report_mismatch("pwm_level", m_tdata[15:0], want.level);
          end
          if (m_tdata[16 +: slpg_pkg::COUNT_BITS] !== want.ms) begin
            report_mismatch("time_in_cycle", m_tdata[16 +: slpg_pkg::COUNT_BITS], want.ms);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transfer. tvalid stays high across back-to-back items; it is
  // only lowered by a sender gap, a drain or a register write.
  task automatic send_advance(input logic advance);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, advance};
    do @(posedge clk); while (!s_tready);
    pending_samples.push_back(step_pattern(advance));
  endtask

  // Hold the sender off until every pending sample has come out
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  // Register write, only issued once the block is idle
  task automatic write_reg(input logic addr, input logic [15:0] data);
    drain_outputs();
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    if (addr == slpg_pkg::REG_MODE) begin
      model_mode = data[2:0];
    end else begin
      model_top = data;
    end
    cfg_we <= 1'b0;
  endtask

  // Top value with the extremes and the zero-top case well represented
  function automatic logic [15:0] pick_top();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3:       return slpg_pkg::DEFAULT_TOP;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) return slpg_pkg::MODE_BREATHE;
    if (r < 5) return slpg_pkg::MODE_FAST;
    if (r < 7) return slpg_pkg::MODE_SLOW;
    if (r == 7) return slpg_pkg::MODE_ON;
    if (r == 8) return slpg_pkg::MODE_OFF;
    return 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, each mode once, top extremes, zero top and zero advance
  task automatic test_directed_cases();
    send_advance(1'b1);            // reset mode is off
    send_advance(1'b0);            // zero advance: counter holds
    write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ON));
    send_advance(1'b1);            // reset top of 255
    write_reg(slpg_pkg::REG_PWM_TOP, 16'd0);
    send_advance(1'b1);            // zero top falls back to 255
    write_reg(slpg_pkg::REG_PWM_TOP, 16'd1);
    send_advance(1'b0);
    write_reg(slpg_pkg::REG_PWM_TOP, 16'hffff);
    send_advance(1'b1);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      write_reg(slpg_pkg::REG_MODE, 16'(m));
      send_advance(1'b1);          // unused codes read as off
    end
    write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_BREATHE));
    send_advance(1'b0);
    send_advance(1'b1);
    write_reg(slpg_pkg::REG_PWM_TOP, 16'd1);
    send_advance(1'b1);
    write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_FAST));
    send_advance(1'b1);
    write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_SLOW));
    send_advance(1'b0);
    write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_OFF));
    send_advance(1'b1);
  endtask

  // Run the counter steadily forward, one segment per pattern:
  // breathing, fast blink (crosses its on-to-off edge), slow blink, breathing again.
  task automatic test_full_cycle_sweep();
    logic [2:0] seg_mode;
    for (int seg = 0; seg < SWEEP_SEGMENTS; seg++) begin
      case (seg)
        1:       seg_mode = slpg_pkg::MODE_FAST;
        2:       seg_mode = slpg_pkg::MODE_SLOW;
        default: seg_mode = slpg_pkg::MODE_BREATHE;
      endcase
      write_reg(slpg_pkg::REG_MODE, 16'(seg_mode));
      write_reg(slpg_pkg::REG_PWM_TOP, (seg == 0) ? 16'hffff : pick_top());
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        send_advance(1'b1);
      end
    end
  endtask

  // Random chunks under one idling profile, reconfigured between chunks
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int sent;
    int chunk_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0:       write_reg(slpg_pkg::REG_MODE, 16'(pick_mode()));
        1:       write_reg(slpg_pkg::REG_PWM_TOP, pick_top());
        default: begin
          write_reg(slpg_pkg::REG_MODE, 16'(pick_mode()));
          write_reg(slpg_pkg::REG_PWM_TOP, pick_top());
        end
      endcase
      chunk_len = $urandom_range(120, 20);
      for (int i = 0; i < chunk_len; i++) begin
        send_advance($urandom_range(99) < 85);
        // sender holds mid-chunk until everything is out, first chunk always
        if (i == chunk_len / 2 && (sent == 0 || $urandom_range(3) == 0)) begin
          drain_outputs();
        end
      end
      sent += chunk_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= 8'd0;
    cfg_we        <= 1'b0;
    cfg_addr      <= slpg_pkg::REG_MODE;
    cfg_data      <= 16'd0;
    fail_count    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 62;
    model_mode    = slpg_pkg::MODE_OFF;
    model_top     = slpg_pkg::DEFAULT_TOP;
    model_ms      = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_full_cycle_sweep();
    test_random_traffic(13, 62);
    test_random_traffic(62, 13);
    test_random_traffic(0, 0);

    // Let the last results out, then watch for stray transfers
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** status_led_pattern_generator_unit: PASSED **");
    end else begin
      $display("** status_led_pattern_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ status_led_pattern_generator_unit.f @@
rtl/core/slpg_pkg.sv
rtl/core/slpg_timebase.sv
rtl/core/slpg_sine_rom.sv
rtl/core/slpg_serial_mult.sv
rtl/core/status_led_pattern_generator_unit.sv
test/tb_status_led_pattern_generator_unit.sv
